// ----- design/uut_pkg.sv -----
// Shared types, constants and the target encoder of the unicode unit transcoder.
package uut_pkg;

    // Encoding codes; codes 5 to 7 act as ASCII
    localparam logic [2:0] ENC_UTF8   = 3'd0;
    localparam logic [2:0] ENC_UTF16  = 3'd1;
    localparam logic [2:0] ENC_UTF32  = 3'd2;
    localparam logic [2:0] ENC_ASCII  = 3'd3;
    localparam logic [2:0] ENC_LATIN1 = 3'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;

    localparam logic [31:0] REPL_RUNE = 32'h0000_FFFD;
    localparam logic [31:0] RUNE_MAX  = 32'h0010_FFFF;
    localparam logic [7:0]  SUBST_CHR = 8'h3F;

    // One decoded rune on its way from the front end to the back end
    typedef struct packed {
        logic [31:0] rune;
        logic        bad;
        logic        fin;
    } rune_rec_t;

    typedef struct packed {
        logic [3:0][31:0] units;
        logic [1:0]       last_idx;
        logic             ok;
    } enc_res_t;

    function automatic enc_res_t encode_rune(input logic [31:0] r_in, input logic [2:0] tgt);
        enc_res_t    res;
        logic [31:0] r;
        logic [31:0] s;
        res          = '0;
        res.ok       = 1'b1;
        r            = r_in;
        s            = '0;
        if ((tgt == ENC_UTF8 || tgt == ENC_UTF16 || tgt == ENC_UTF32) && r > RUNE_MAX)
        begin
            r      = REPL_RUNE;
            res.ok = 1'b0;
        end
        case (tgt)
            ENC_UTF8:
            begin
                if (r <= 32'h7F)
                begin
                    res.units[0] = r;
                end
                else if (r <= 32'h7FF)
                begin
                    res.units[0] = {24'h0, 3'b110, r[10:6]};
                    res.units[1] = {24'h0, 2'b10, r[5:0]};
                    res.last_idx = 2'd1;
                end
                else if (r <= 32'hFFFF)
                begin
                    res.units[0] = {24'h0, 4'b1110, r[15:12]};
                    res.units[1] = {24'h0, 2'b10, r[11:6]};
                    res.units[2] = {24'h0, 2'b10, r[5:0]};
                    res.last_idx = 2'd2;
                end
                else
                begin
                    res.units[0] = {24'h0, 5'b11110, r[20:18]};
                    res.units[1] = {24'h0, 2'b10, r[17:12]};
                    res.units[2] = {24'h0, 2'b10, r[11:6]};
                    res.units[3] = {24'h0, 2'b10, r[5:0]};
                    res.last_idx = 2'd3;
                end
            end
            ENC_UTF16:
            begin
                if (r <= 32'hFFFF)
                begin
                    res.units[0] = r;
                end
                else
                begin
                    s            = r - 32'h0001_0000;
                    res.units[0] = {16'h0, 6'b110110, s[19:10]};
                    res.units[1] = {16'h0, 6'b110111, s[9:0]};
                    res.last_idx = 2'd1;
                end
            end
            ENC_UTF32:
            begin
                res.units[0] = r;
            end
            ENC_LATIN1:
            begin
                if (r <= 32'hFF)
                begin
                    res.units[0] = r;
                end
                else
                begin
                    res.units[0] = {24'h0, SUBST_CHR};
                    res.ok       = 1'b0;
                end
            end
            default:
            begin
                if (r <= 32'h7F)
                begin
                    res.units[0] = r;
                end
                else
                begin
                    res.units[0] = {24'h0, SUBST_CHR};
                    res.ok       = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

endpackage

// ----- design/uut_front.sv -----
// Front end: accepts source words, keeps partial sequences and decodes whole runes.
module uut_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           src_enc,
    input  logic                 src_wr,
    input  logic                 push,
    input  logic [31:0]          unit_in,
    input  logic                 stream_last,
    input  logic                 q_full,
    output logic                 q_wr,
    output uut_pkg::rune_rec_t   q_rec
);

    logic [20:0] part_reg, part_next;
    logic [1:0]  due_reg, due_next;
    logic        hsw_reg, hsw_next;
    logic        emit;
    logic        accept;
    logic [7:0]  b;
    logic [15:0] h;
    logic [20:0] cont;
    logic [1:0]  due_dec;

    assign accept  = push && !q_full;
    assign b       = unit_in[7:0];
    assign h       = unit_in[15:0];
    assign cont    = {part_reg[14:0], b[5:0]};
    assign due_dec = due_reg - 2'd1;

    always_comb
    begin
        part_next   = part_reg;
        due_next    = due_reg;
        hsw_next    = hsw_reg;
        emit        = 1'b0;
        q_rec.rune  = {24'h0, b};
        q_rec.bad   = 1'b0;
        q_rec.fin   = stream_last;
        case (src_enc)
            uut_pkg::ENC_UTF8:
            begin
                if (due_reg != 2'd0)
                begin
                    if (due_dec == 2'd0)
                    begin
                        emit       = 1'b1;
                        q_rec.rune = {11'h0, cont};
                        part_next  = '0;
                        due_next   = '0;
                    end
                    else if (stream_last)
                    begin
                        // truncated at end of stream
                        emit       = 1'b1;
                        q_rec.rune = uut_pkg::REPL_RUNE;
                        q_rec.bad  = 1'b1;
                        part_next  = '0;
                        due_next   = '0;
                        hsw_next   = 1'b0;
                    end
                    else
                    begin
                        part_next = cont;
                        due_next  = due_dec;
                    end
                end
                else if (b[7:3] == 5'b11110 || b[7:4] == 4'b1110 || b[7:5] == 3'b110)
                begin
                    if (stream_last)
                    begin
                        emit       = 1'b1;
                        q_rec.rune = uut_pkg::REPL_RUNE;
                        q_rec.bad  = 1'b1;
                        part_next  = '0;
                        due_next   = '0;
                        hsw_next   = 1'b0;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        part_next = {18'h0, b[2:0]};
                        due_next  = 2'd3;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        part_next = {17'h0, b[3:0]};
                        due_next  = 2'd2;
                    end
                    else
                    begin
                        part_next = {16'h0, b[4:0]};
                        due_next  = 2'd1;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    if (b[7])
                    begin
                        q_rec.rune = uut_pkg::REPL_RUNE;
                        q_rec.bad  = 1'b1;
                    end
                end
            end
            uut_pkg::ENC_UTF16:
            begin
                if (hsw_reg)
                begin
                    emit      = 1'b1;
                    part_next = '0;
                    due_next  = '0;
                    hsw_next  = 1'b0;
                    if (h[15:10] == 6'b110111)
                    begin
                        q_rec.rune = 32'h0001_0000 + {12'h0, part_reg[9:0], h[9:0]};
                    end
                    else
                    begin
                        q_rec.rune = uut_pkg::REPL_RUNE;
                        q_rec.bad  = 1'b1;
                    end
                end
                else if (h[15:10] == 6'b110110)
                begin
                    if (stream_last)
                    begin
                        emit       = 1'b1;
                        q_rec.rune = uut_pkg::REPL_RUNE;
                        q_rec.bad  = 1'b1;
                    end
                    else
                    begin
                        hsw_next  = 1'b1;
                        part_next = {11'h0, h[9:0]};
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    q_rec.rune = {16'h0, h};
                end
            end
            uut_pkg::ENC_UTF32:
            begin
                emit       = 1'b1;
                q_rec.rune = unit_in;
            end
            uut_pkg::ENC_LATIN1:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b1;
                if (b[7])
                begin
                    q_rec.rune = uut_pkg::REPL_RUNE;
                    q_rec.bad  = 1'b1;
                end
            end
        endcase
    end

    assign q_wr = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            due_reg  <= '0;
            hsw_reg  <= 1'b0;
        end
        else if (src_wr)
        begin
            // drop any partial rune on a source change
            part_reg <= '0;
            due_reg  <= '0;
            hsw_reg  <= 1'b0;
        end
        else if (accept)
        begin
            part_reg <= part_next;
            due_reg  <= due_next;
            hsw_reg  <= hsw_next;
        end
    end

endmodule

// ----- design/uut_fifo.sv -----
// Short rune queue between the front end and the back end.
module uut_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  uut_pkg::rune_rec_t   wr_rec,
    output logic                 full,
    input  logic                 rd,
    output logic                 rd_valid,
    output uut_pkg::rune_rec_t   rd_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    uut_pkg::rune_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_wr;
    logic               do_rd;

    assign full     = (cnt_reg == CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/uut_back.sv -----
// Back end: encodes one rune into target words and sends them out one per cycle while results are popped.
module uut_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           tgt_enc,
    input  logic                 q_valid,
    input  uut_pkg::rune_rec_t   q_rec,
    output logic                 q_rd,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          unit_out,
    output logic                 decode_bad,
    output logic                 encode_ok,
    output logic                 rune_last,
    output logic                 stream_done
);

    uut_pkg::rune_rec_t cur_reg;
    logic               cur_valid_reg;
    logic [1:0]         idx_reg;
    uut_pkg::enc_res_t  enc;
    logic               out_valid_reg;
    logic [31:0]        unit_reg;
    logic               bad_reg;
    logic               ok_reg;
    logic               rlast_reg;
    logic               done_reg;
    logic               out_free;
    logic               send;
    logic               last_unit;

    assign enc       = uut_pkg::encode_rune(cur_reg.rune, tgt_enc);
    assign out_free  = !out_valid_reg || pop;
    assign send      = cur_valid_reg && out_free;
    assign last_unit = (idx_reg == enc.last_idx);
    assign q_rd      = q_valid && (!cur_valid_reg || (send && last_unit));

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cur_reg <= q_rec;
        end
        if (send)
        begin
            unit_reg  <= enc.units[idx_reg];
            bad_reg   <= cur_reg.bad;
            ok_reg    <= enc.ok;
            rlast_reg <= last_unit;
            done_reg  <= last_unit && cur_reg.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // advance to the next rune once the last word of this one is out
            if (q_rd)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (send && last_unit)
            begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (send)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (send)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign unit_out    = unit_reg;
    assign decode_bad  = bad_reg;
    assign encode_ok   = ok_reg;
    assign rune_last   = rlast_reg;
    assign stream_done = done_reg;

endmodule

// ----- design/unicode_unit_transcoder.sv -----
// Unicode code unit transcoder. Source words (UTF-8, UTF-16, UTF-32, ASCII or Latin-1)
// are pushed one per cycle; the front end decodes them to runes and hands each whole rune
// to a FIFO_DEPTH-entry queue, and the back end encodes a rune into 1 to 4 target words,
// sending one word per cycle through an output register as long as results are popped.
// An input word is taken every cycle as long as the queue has room; the back end is the
// limit, as it sends the target words of a rune one at a time. A rune passes through the
// queue and the current-rune register, and its first word through the output register,
// before that word shows on the result ports. Change encodings only while idle; writing the
// source encoding drops any partial sequence.
module unicode_unit_transcoder
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [uut_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [2:0]                     cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [31:0]                    unit_in,
    input  logic                           stream_last,
    output logic                           empty,
    input  logic                           pop,
    output logic [31:0]                    unit_out,
    output logic                           decode_bad,
    output logic                           encode_ok,
    output logic                           rune_last,
    output logic                           stream_done
);

    logic [2:0]         src_reg;
    logic [2:0]         tgt_reg;
    logic               src_wr;
    logic               q_wr;
    logic               q_rd;
    logic               q_valid;
    uut_pkg::rune_rec_t wr_rec;
    uut_pkg::rune_rec_t rd_rec;

    assign src_wr = cfg_we && (cfg_index == uut_pkg::REG_SOURCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= uut_pkg::ENC_UTF8;
            tgt_reg <= uut_pkg::ENC_UTF16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == uut_pkg::REG_SOURCE)
            begin
                src_reg <= cfg_data;
            end
            else if (cfg_index == uut_pkg::REG_TARGET)
            begin
                tgt_reg <= cfg_data;
            end
        end
    end

    uut_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_enc     (src_reg),
        .src_wr      (src_wr),
        .push        (push),
        .unit_in     (unit_in),
        .stream_last (stream_last),
        .q_full      (full),
        .q_wr        (q_wr),
        .q_rec       (wr_rec)
    );

    uut_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_rec   (wr_rec),
        .full     (full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_rec   (rd_rec)
    );

    uut_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tgt_enc     (tgt_reg),
        .q_valid     (q_valid),
        .q_rec       (rd_rec),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .unit_out    (unit_out),
        .decode_bad  (decode_bad),
        .encode_ok   (encode_ok),
        .rune_last   (rune_last),
        .stream_done (stream_done)
    );

endmodule

// ----- design/uut_chk.sv -----
// Port-level checks for the unicode unit transcoder, bound to the top level.
module uut_chk
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] unit_out,
    input  logic        encode_ok,
    input  logic        rune_last,
    input  logic        stream_done
);

    // hold a waiting word until it is popped
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(unit_out))
        else $error("waiting result word changed or vanished");

    a_done_ends_rune: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && stream_done |-> rune_last)
        else $error("stream end flagged inside a rune");

    // a substitute ends in '?', U+FFFD, or the last UTF-8 byte of U+FFFD
    a_subst_value: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !encode_ok && rune_last |->
            unit_out == 32'h3F || unit_out == 32'hFFFD || unit_out == 32'hBD)
        else $error("unexpected substitute value");

    a_subst_lead: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !encode_ok && !rune_last |->
            unit_out == 32'hEF || unit_out == 32'hBF)
        else $error("unexpected substitute lead byte");

endmodule

bind unicode_unit_transcoder uut_chk u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .unit_out    (unit_out),
    .encode_ok   (encode_ok),
    .rune_last   (rune_last),
    .stream_done (stream_done)
);
